// File: sv/jsu_pkg.sv
`timescale 1ns / 1ps

package jsu_pkg;

    // Result kinds as they appear on the result channel.
    typedef enum logic [2:0] {
        K_DATA   = 3'd0,
        K_END    = 3'd1,
        K_BADESC = 3'd2,
        K_BADHEX = 3'd3,
        K_CTRL   = 3'd4
    } kind_t;

    // Decoder phase.
    typedef enum logic [2:0] {
        PH_TEXT,
        PH_ESC,
        PH_HEX,
        PH_DONE,
        PH_DEAD
    } phase_t;

    localparam int unsigned MaxRes = 4;

    localparam logic [7:0] ChQuote     = 8'h22;
    localparam logic [7:0] ChBackslash = 8'h5C;
    localparam logic [7:0] ChU         = 8'h75;
    localparam logic [7:0] CtrlLimit   = 8'h20;

    localparam logic [15:0] HighSurLo = 16'hD800;
    localparam logic [15:0] HighSurHi = 16'hDBFF;
    localparam logic [20:0] SuppBase  = 21'h10000;

    // One result beat held in the output buffer.
    typedef struct packed {
        logic [7:0] out_byte;
        kind_t      kind;
        logic       last;
    } res_t;

    // A UTF-8 encoding: up to four bytes, first byte at index 0.
    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      n;
    } enc_t;

    // Hex digit value with a valid flag in the top bit.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

    // Named escape character with a valid flag in the top bit.
    function automatic logic [8:0] named_escape(input logic [7:0] c);
        logic [8:0] r;
        r = 9'd0;
        case (c)
            8'h22: r = {1'b1, 8'h22};
            8'h5C: r = {1'b1, 8'h5C};
            8'h2F: r = {1'b1, 8'h2F};
            8'h62: r = {1'b1, 8'h08};
            8'h66: r = {1'b1, 8'h0C};
            8'h74: r = {1'b1, 8'h09};
            8'h72: r = {1'b1, 8'h0D};
            8'h6E: r = {1'b1, 8'h0A};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic enc_t utf8_encode(input logic [20:0] cp);
        enc_t e;
        e.b = '0;
        if (cp < 21'h80) begin
            e.b[0] = cp[7:0];
            e.n    = 3'd1;
        end
        else if (cp < 21'h800) begin
            e.b[0] = {3'b110, cp[10:6]};
            e.b[1] = {2'b10, cp[5:0]};
            e.n    = 3'd2;
        end
        else if (cp < 21'h10000) begin
            e.b[0] = {4'b1110, cp[15:12]};
            e.b[1] = {2'b10, cp[11:6]};
            e.b[2] = {2'b10, cp[5:0]};
            e.n    = 3'd3;
        end
        else begin
            e.b[0] = {5'b11110, cp[20:18]};
            e.b[1] = {2'b10, cp[17:12]};
            e.b[2] = {2'b10, cp[11:6]};
            e.b[3] = {2'b10, cp[5:0]};
            e.n    = 3'd4;
        end
        return e;
    endfunction

endpackage

// File: sv/jsu_in_if.sv
`timescale 1ns / 1ps

interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       restart;

    modport source (output valid, output in_byte, output restart, input ready);
    modport sink   (input valid, input in_byte, input restart, output ready);
endinterface

// File: sv/jsu_out_if.sv
`timescale 1ns / 1ps

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] kind;
    logic       last;

    modport source (output valid, output out_byte, output kind, output last, input ready);
    modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface

// File: sv/json_string_unescape_utf8_top.sv
`timescale 1ns / 1ps

// Channel  Direction  Beat payload                 Notes
// rx       in         in_byte[7:0], restart        one raw string-body byte per beat
// tx       out        out_byte[7:0], kind[2:0],    0 to 4 beats per rx beat,
//                     last                         last marks the final one
//
// Each rx beat is decoded in the cycle it is accepted and its results land in a
// four-entry output buffer, leaving at one beat per cycle from the next cycle.
// A byte's results hold off the next byte until they have all left, which sets
// the input rate; rx is ready when the buffer is empty or its last
// entry is leaving this cycle. Reset (rst_n low, asynchronous) empties the buffer
// and returns the decoder to normal text. A tx stall holds the head, and so rx.

module json_string_unescape_utf8_top
(
    input  logic          clk,
    input  logic          rst_n,
    jsu_in_if.sink        rx,
    jsu_out_if.source     tx
);

    import jsu_pkg::*;

    // Decoder state.
    phase_t      phase_reg, phase_next;
    logic [15:0] accum_reg, accum_next;
    logic [1:0]  digits_reg, digits_next;
    logic [9:0]  held_reg, held_next;
    logic        held_v_reg, held_v_next;

    // Output buffer: a short shift line, head at index zero.
    res_t        buf_reg [MaxRes];
    res_t        buf_next [MaxRes];
    logic [2:0]  cnt_reg, cnt_next;

    logic        in_acc;
    logic        out_acc;

    // State as seen by the current byte, after any restart.
    phase_t      phase_eff;
    logic [15:0] accum_eff;
    logic [1:0]  digits_eff;
    logic [9:0]  held_eff;
    logic        held_v_eff;

    logic [7:0]  c;
    logic [4:0]  hv;
    logic [8:0]  ne;
    logic [15:0] v;
    logic [20:0] cp;
    enc_t        enc;

    // Decisions for this byte.
    logic        flush;
    logic [2:0]  main_n;
    kind_t       main_kind;
    logic [3:0][7:0] main_b;

    assign c   = rx.in_byte;
    assign hv  = hex_val(c);
    assign ne  = named_escape(c);
    assign v   = {accum_eff[11:0], hv[3:0]};

    assign in_acc  = rx.valid && rx.ready;
    assign out_acc = tx.valid && tx.ready;

    assign rx.ready = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && tx.ready);

    always_comb
    begin
        if (rx.restart)
        begin
            phase_eff  = PH_TEXT;
            accum_eff  = '0;
            digits_eff = '0;
            held_eff   = '0;
            held_v_eff = 1'b0;
        end
        else
        begin
            phase_eff  = phase_reg;
            accum_eff  = accum_reg;
            digits_eff = digits_reg;
            held_eff   = held_reg;
            held_v_eff = held_v_reg;
        end
    end

    // Next state and the decisions that shape this byte's results.
    always_comb
    begin
        phase_next  = phase_eff;
        accum_next  = accum_eff;
        digits_next = digits_eff;
        held_next   = held_eff;
        held_v_next = held_v_eff;
        flush       = 1'b0;
        main_n      = 3'd0;
        main_kind   = K_DATA;
        main_b      = '0;
        cp          = {5'd0, v};
        enc         = utf8_encode(cp);

        unique case (phase_eff) inside
            PH_TEXT:
            begin
                if (c != ChBackslash)
                begin
                    // Anything but a backslash releases a held surrogate first.
                    flush       = held_v_eff;
                    held_next   = '0;
                    held_v_next = 1'b0;
                end
                if (c == ChQuote)
                begin
                    main_n     = 3'd1;
                    main_kind  = K_END;
                    phase_next = PH_DONE;
                end
                else if (c == ChBackslash)
                begin
                    phase_next = PH_ESC;
                end
                else if (c < CtrlLimit)
                begin
                    main_n     = 3'd1;
                    main_kind  = K_CTRL;
                    phase_next = PH_DEAD;
                end
                else
                begin
                    main_n    = 3'd1;
                    main_b[0] = c;
                end
            end
            PH_ESC:
            begin
                if (c == ChU)
                begin
                    phase_next  = PH_HEX;
                    accum_next  = '0;
                    digits_next = '0;
                end
                else if (ne[8])
                begin
                    flush       = held_v_eff;
                    held_next   = '0;
                    held_v_next = 1'b0;
                    main_n      = 3'd1;
                    main_b[0]   = ne[7:0];
                    phase_next  = PH_TEXT;
                end
                else
                begin
                    // A bad escape drops any held surrogate silently.
                    held_next   = '0;
                    held_v_next = 1'b0;
                    main_n      = 3'd1;
                    main_kind   = K_BADESC;
                    phase_next  = PH_DEAD;
                end
            end
            PH_HEX:
            begin
                if (!hv[4])
                begin
                    held_next   = '0;
                    held_v_next = 1'b0;
                    main_n      = 3'd1;
                    main_kind   = K_BADHEX;
                    phase_next  = PH_DEAD;
                end
                else
                begin
                    // Release a held surrogate once the value can no longer
                    // turn out to be a low surrogate.
                    if (held_v_eff &&
                        (((digits_eff == 2'd0) && (hv[3:0] != 4'hD)) ||
                         ((digits_eff == 2'd1) && (hv[3:0] < 4'hC))))
                    begin
                        flush       = 1'b1;
                        held_next   = '0;
                        held_v_next = 1'b0;
                    end
                    accum_next = v;
                    if (digits_eff != 2'd3)
                    begin
                        digits_next = digits_eff + 2'd1;
                    end
                    else
                    begin
                        digits_next = '0;
                        accum_next  = '0;
                        phase_next  = PH_TEXT;
                        if (held_v_eff)
                        begin
                            // Pair with the held high surrogate.
                            cp          = SuppBase + {1'b0, held_eff, v[9:0]};
                            enc         = utf8_encode(cp);
                            main_n      = enc.n;
                            main_b      = enc.b;
                            held_next   = '0;
                            held_v_next = 1'b0;
                        end
                        else if ((v >= HighSurLo) && (v <= HighSurHi))
                        begin
                            held_next   = v[9:0];
                            held_v_next = 1'b1;
                        end
                        else
                        begin
                            main_n = enc.n;
                            main_b = enc.b;
                        end
                    end
                end
            end
            PH_DONE, PH_DEAD:
            begin
                phase_next = phase_eff;
            end
            default:
            begin
                phase_next = phase_eff;
            end
        endcase
    end

    // Result entries and the buffer's next contents.
    always_comb
    begin
        res_t       ent [MaxRes];
        logic [2:0] n;

        for (int i = 0; i < MaxRes; i++)
        begin
            ent[i] = '{out_byte: 8'h00, kind: K_DATA, last: 1'b0};
        end

        if (flush)
        begin
            // A lone high surrogate D800+h encodes as ED, A0|h[9:6], 80|h[5:0].
            ent[0].out_byte = 8'hED;
            ent[1].out_byte = {4'hA, held_eff[9:6]};
            ent[2].out_byte = {2'b10, held_eff[5:0]};
            ent[3].out_byte = main_b[0];
            ent[3].kind     = main_kind;
            n               = 3'd3 + main_n;
        end
        else
        begin
            for (int i = 0; i < MaxRes; i++)
            begin
                ent[i].out_byte = main_b[i];
                ent[i].kind     = main_kind;
            end
            n = main_n;
        end

        for (int i = 0; i < MaxRes; i++)
        begin
            ent[i].last = (3'(i) == (n - 3'd1));
        end

        if (in_acc)
        begin
            for (int i = 0; i < MaxRes; i++)
            begin
                buf_next[i] = ent[i];
            end
            cnt_next = n;
        end
        else if (out_acc)
        begin
            for (int i = 0; i < MaxRes - 1; i++)
            begin
                buf_next[i] = buf_reg[i + 1];
            end
            buf_next[MaxRes - 1] = buf_reg[MaxRes - 1];
            cnt_next = cnt_reg - 3'd1;
        end
        else
        begin
            for (int i = 0; i < MaxRes; i++)
            begin
                buf_next[i] = buf_reg[i];
            end
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TEXT;
            accum_reg  <= '0;
            digits_reg <= '0;
            held_reg   <= '0;
            held_v_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                phase_reg  <= phase_next;
                accum_reg  <= accum_next;
                digits_reg <= digits_next;
                held_reg   <= held_next;
                held_v_reg <= held_v_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MaxRes; i++)
        begin
            buf_reg[i] <= buf_next[i];
        end
    end

    assign tx.valid    = (cnt_reg != 3'd0);
    assign tx.out_byte = buf_reg[0].out_byte;
    assign tx.kind     = buf_reg[0].kind;
    assign tx.last     = buf_reg[0].last;

    // The buffer never holds more than one byte's worth of results.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'(MaxRes))
        else $error("output buffer count out of range");

    // The marked final beat is always the last entry in the buffer.
    a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (tx.valid && tx.last) |-> (cnt_reg == 3'd1))
        else $error("last beat presented with entries still behind it");

    // Only data beats carry a byte value.
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (tx.valid && (tx.kind != K_DATA)) |-> (tx.out_byte == 8'h00))
        else $error("non-data beat with nonzero byte");

    // An error beat leaves the decoder dead with nothing held.
    a_err_dead: assert property (@(posedge clk) disable iff (!rst_n)
        (tx.valid && ((tx.kind == K_BADESC) || (tx.kind == K_BADHEX) ||
                      (tx.kind == K_CTRL)))
        |-> ((phase_reg == PH_DEAD) && !held_v_reg))
        else $error("error beat without dead decoder");

    // A surrogate is held only while the string is still open.
    a_held_open: assert property (@(posedge clk) disable iff (!rst_n)
        held_v_reg |-> ((phase_reg == PH_TEXT) || (phase_reg == PH_ESC) ||
                        (phase_reg == PH_HEX)))
        else $error("surrogate held after end of string");

endmodule

// File: tb/sv/jsu_decode_checker.sv
`timescale 1ns / 1ps

module jsu_decode_checker
(
    input  logic  clk,
    input  logic  rst_n,
    jsu_in_if     rx,
    jsu_out_if    tx,
    output int    mismatches,
    output int    pending,
    output int    beats_checked,
    output int    end_marks,
    output int    error_marks
);

    import jsu_pkg::*;

    // Decoder state as this side sees it.
    phase_t      ph    = PH_TEXT;
    logic [15:0] acc   = '0;
    logic [1:0]  ndig  = '0;
    logic [9:0]  hsur  = '0;
    logic        hheld = 1'b0;

    res_t byte_beats[$];
    res_t utf8_expected[$];

    task automatic clear_decoder();
        ph    = PH_TEXT;
        acc   = '0;
        ndig  = '0;
        hsur  = '0;
        hheld = 1'b0;
    endtask

    task automatic emit(input logic [7:0] b, input kind_t k);
        res_t r;
        r.out_byte = (k == K_DATA) ? b : 8'h00;
        r.kind     = k;
        r.last     = 1'b0;
        byte_beats.push_back(r);
    endtask

    task automatic encode_cp(input logic [20:0] cp);
        if (cp < 21'h80) begin
            emit(cp[7:0], K_DATA);
        end
        else if (cp < 21'h800) begin
            emit({3'b110, cp[10:6]}, K_DATA);
            emit({2'b10, cp[5:0]}, K_DATA);
        end
        else if (cp < 21'h10000) begin
            emit({4'b1110, cp[15:12]}, K_DATA);
            emit({2'b10, cp[11:6]}, K_DATA);
            emit({2'b10, cp[5:0]}, K_DATA);
        end
        else begin
            emit({5'b11110, cp[20:18]}, K_DATA);
            emit({2'b10, cp[17:12]}, K_DATA);
            emit({2'b10, cp[11:6]}, K_DATA);
            emit({2'b10, cp[5:0]}, K_DATA);
        end
    endtask

    // A held high surrogate that finds no partner goes out as three bytes.
    task automatic release_held();
        if (hheld) begin
            encode_cp({5'b0, 6'b110110, hsur});
            hheld = 1'b0;
            hsur  = '0;
        end
    endtask

    task automatic abort(input kind_t k);
        hheld = 1'b0;
        hsur  = '0;
        ph    = PH_DEAD;
        emit(8'h00, k);
    endtask

    function automatic logic nibble_of(input logic [7:0] c, output logic [3:0] n);
        n = 4'h0;
        if (c >= "0" && c <= "9") begin
            n = 4'(c - "0");
            return 1'b1;
        end
        if (c >= "A" && c <= "F") begin
            n = 4'(c - "A" + 8'd10);
            return 1'b1;
        end
        if (c >= "a" && c <= "f") begin
            n = 4'(c - "a" + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic escape_char(input logic [7:0] c, output logic [7:0] ch);
        ch = 8'h00;
        case (c)
            "\"":    ch = 8'h22;
            "\\":    ch = 8'h5C;
            "/":     ch = 8'h2F;
            "b":     ch = 8'h08;
            "f":     ch = 8'h0C;
            "t":     ch = 8'h09;
            "r":     ch = 8'h0D;
            "n":     ch = 8'h0A;
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    task automatic take_hex(input logic [7:0] c);
        logic [3:0]  n;
        logic [15:0] v;
        if (!nibble_of(c, n)) begin
            abort(K_BADHEX);
            return;
        end
        // The held surrogate is let go as soon as the new value cannot be low.
        if (ndig == 2'd0 && hheld && n != 4'hD) begin
            release_held();
        end
        if (ndig == 2'd1 && hheld && n < 4'hC) begin
            release_held();
        end
        acc = {acc[11:0], n};
        if (ndig != 2'd3) begin
            ndig = ndig + 2'd1;
            return;
        end
        v    = acc;
        ndig = '0;
        acc  = '0;
        ph   = PH_TEXT;
        if (hheld) begin
            encode_cp(SuppBase + {1'b0, hsur, 10'b0} + {11'b0, v[9:0]});
            hheld = 1'b0;
            hsur  = '0;
        end
        else if (v >= HighSurLo && v <= HighSurHi) begin
            hsur  = v[9:0];
            hheld = 1'b1;
        end
        else begin
            encode_cp({5'b0, v});
        end
    endtask

    task automatic decode_byte(input logic [7:0] c, input logic rs);
        logic [7:0] ch;
        byte_beats.delete();
        if (rs) begin
            clear_decoder();
        end
        case (ph)
            PH_TEXT: begin
                if (c != ChBackslash) begin
                    release_held();
                end
                if (c == ChQuote) begin
                    emit(8'h00, K_END);
                    ph = PH_DONE;
                end
                else if (c == ChBackslash) begin
                    ph = PH_ESC;
                end
                else if (c < CtrlLimit) begin
                    abort(K_CTRL);
                end
                else begin
                    emit(c, K_DATA);
                end
            end
            PH_ESC: begin
                if (c == ChU) begin
                    ph   = PH_HEX;
                    acc  = '0;
                    ndig = '0;
                end
                else if (escape_char(c, ch)) begin
                    release_held();
                    emit(ch, K_DATA);
                    ph = PH_TEXT;
                end
                else begin
                    abort(K_BADESC);
                end
            end
            PH_HEX: begin
                take_hex(c);
            end
            default: begin
            end
        endcase
        if (byte_beats.size() > 0) begin
            byte_beats[byte_beats.size() - 1].last = 1'b1;
        end
        foreach (byte_beats[i]) begin
            utf8_expected.push_back(byte_beats[i]);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        res_t want;
        if (!rst_n) begin
            clear_decoder();
            utf8_expected.delete();
            pending       <= 0;
            mismatches    <= 0;
            beats_checked <= 0;
            end_marks     <= 0;
            error_marks   <= 0;
        end
        else begin
            if (rx.valid && rx.ready) begin
                decode_byte(rx.in_byte, rx.restart);
            end
            if (tx.valid && tx.ready) begin
                beats_checked <= beats_checked + 1;
                if (tx.kind == K_END) begin
                    end_marks <= end_marks + 1;
                end
                else if (tx.kind != K_DATA) begin
                    error_marks <= error_marks + 1;
                end
                if (utf8_expected.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t: unexpected beat: byte %02h kind %0d last %0b",
                                 $time, tx.out_byte, tx.kind, tx.last);
                    end
                    mismatches <= mismatches + 1;
                end
                else begin
                    want = utf8_expected.pop_front();
                    if (tx.out_byte !== want.out_byte || tx.kind !== want.kind
                        || tx.last !== want.last) begin
                        if (mismatches < 10) begin
                            $display("%0t: mismatch: want %02h/%0d/%0b, got %02h/%0d/%0b",
                                     $time, want.out_byte, want.kind, want.last,
                                     tx.out_byte, tx.kind, tx.last);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
            pending <= utf8_expected.size();
        end
    end

endmodule

// File: tb/sv/tb_json_string_unescape_utf8_top.sv
`timescale 1ns / 1ps

module tb_json_string_unescape_utf8_top;

    import jsu_pkg::*;

    // Number of live string bytes, the directed opening included, that the run
    // aims for, in even quarters of the target over the four handshake phases.
    localparam int Items = 280;

    // The eight characters that may follow a backslash as a named escape.
    localparam logic [7:0] EscChars [8] = '{"\"", "\\", "/", "b", "f", "t", "r", "n"};

    // Code points on the edges of the UTF-8 length classes and of the
    // surrogate ranges.
    localparam logic [15:0] Bounds [12] = '{
        16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF,
        16'hD7FF, 16'hD800, 16'hDBFF, 16'hDC00, 16'hDFFF, 16'hE000
    };

    // Idling per phase: no idling, sender idle, receiver stalling, both.
    localparam int IdlePct  [4] = '{0, 49, 0, 30};
    localparam int StallPct [4] = '{0, 0, 49, 30};

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    jsu_in_if  rx_ch ();
    jsu_out_if tx_ch ();

    logic sink_ready = 1'b0;
    assign tx_ch.ready = sink_ready;

    int   idle_pct    = 0;
    int   stall_pct   = 0;
    int   fed         = 0;
    logic restart_next = 1'b0;
    // Cleared once the current string has been closed or has failed, so
    // that the bytes the block merely discards are not counted as fed.
    logic live        = 1'b1;

    int mismatches;
    int pending;
    int beats_checked;
    int end_marks;
    int error_marks;

    always #1 clk = ~clk;

    json_string_unescape_utf8_top dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .tx    (tx_ch)
    );

    jsu_decode_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx            (rx_ch),
        .tx            (tx_ch),
        .mismatches    (mismatches),
        .pending       (pending),
        .beats_checked (beats_checked),
        .end_marks     (end_marks),
        .error_marks   (error_marks)
    );

    // The receiver stalls at random at the rate the current phase asks for.
    always @(posedge clk) begin
        sink_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Whole run limit: far beyond the slowest correct run, even with every
    // byte giving four beats behind a heavily stalled receiver.
    initial begin
        #400000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [7:0] hex_char(input logic [3:0] n, input logic lower);
        if (n < 4'd10) begin
            return 8'("0") + 8'(n);
        end
        return (lower ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
    endfunction

    function automatic logic is_hex_char(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    function automatic logic is_escape_char(input logic [7:0] c);
        foreach (EscChars[i]) begin
            if (c == EscChars[i]) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Offers one beat on rx and returns once it has been taken. Valid is
    // only lowered when a gap is actually inserted, so that back-to-back
    // beats never see valid assigned twice in one time step.
    task automatic put_byte(input logic [7:0] b);
        if ($urandom_range(99) < idle_pct) begin
            rx_ch.valid   <= 1'b0;
            rx_ch.in_byte <= 8'($urandom());
            @(posedge clk);
            while ($urandom_range(99) < idle_pct) begin
                @(posedge clk);
            end
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.in_byte <= b;
        rx_ch.restart <= restart_next;
        restart_next = 1'b0;
        @(posedge clk);
        while (!rx_ch.ready) begin
            @(posedge clk);
        end
        if (live) begin
            fed++;
        end
    endtask

    // A \uXXXX escape, each hex digit in a random case.
    task automatic put_u16(input logic [15:0] v);
        put_byte(ChBackslash);
        put_byte(ChU);
        for (int i = 3; i >= 0; i--) begin
            put_byte(hex_char(v[i*4 +: 4], 1'($urandom_range(1))));
        end
    endtask

    task automatic put_plain();
        logic [7:0] c;
        c = 8'($urandom_range(8'h20, 8'hFF));
        while (c == ChQuote || c == ChBackslash) begin
            c = 8'($urandom_range(8'h20, 8'hFF));
        end
        put_byte(c);
    endtask

    // A random \u escape. Surrogates are made common, since the pairing
    // rules and the release of a held high half are where most of the
    // decoder's corners lie.
    task automatic put_unicode();
        case ($urandom_range(7))
            0: put_u16(16'($urandom_range(16'h7F)));
            1: put_u16(16'($urandom_range(16'h80, 16'h7FF)));
            2: put_u16(16'($urandom_range(16'h800, 16'hFFFF)));
            3: begin
                put_u16(16'($urandom_range(16'hD800, 16'hDBFF)));
                put_u16(16'($urandom_range(16'hDC00, 16'hDFFF)));
            end
            4: put_u16(16'($urandom_range(16'hD800, 16'hDBFF)));
            5: put_u16(16'($urandom_range(16'hDC00, 16'hDFFF)));
            6: put_u16(Bounds[$urandom_range(11)]);
            default: begin
                // High half followed by a random \u, which is seldom its partner.
                put_u16(16'($urandom_range(16'hD800, 16'hDBFF)));
                put_u16(16'($urandom_range(16'hFFFF)));
            end
        endcase
    endtask

    // One error token; the string is dead afterwards.
    task automatic put_error();
        logic [7:0] c;
        case ($urandom_range(2))
            0: put_byte(8'($urandom_range(8'h1F)));
            1: begin
                c = 8'($urandom());
                while (is_escape_char(c) || c == ChU) begin
                    c = 8'($urandom());
                end
                put_byte(ChBackslash);
                put_byte(c);
            end
            default: begin
                c = 8'($urandom());
                while (is_hex_char(c)) begin
                    c = 8'($urandom());
                end
                put_byte(ChBackslash);
                put_byte(ChU);
                repeat ($urandom_range(3)) begin
                    put_byte(hex_char(4'($urandom()), 1'($urandom_range(1))));
                end
                put_byte(c);
            end
        endcase
        live = 1'b0;
    endtask

    // Most strings are well formed with random content; a few are broken
    // by an error token, and some are plain noise with random restarts.
    task automatic put_string();
        int  ntok;
        int  pick;
        logic dead;
        dead         = 1'b0;
        live         = 1'b1;
        restart_next = 1'b1;
        if ($urandom_range(99) < 12) begin
            repeat ($urandom_range(1, 8)) begin
                put_byte(8'($urandom()));
                restart_next = ($urandom_range(99) < 8);
            end
            return;
        end
        ntok = $urandom_range(1, 10);
        for (int i = 0; i < ntok && !dead; i++) begin
            pick = $urandom_range(99);
            if (pick < 40 || pick >= 92) begin
                put_plain();
            end
            else if (pick < 55) begin
                put_byte(ChBackslash);
                put_byte(EscChars[$urandom_range(7)]);
            end
            else if (pick < 85) begin
                put_unicode();
            end
            else begin
                put_error();
                dead = 1'b1;
            end
        end
        if (!dead && $urandom_range(99) < 85) begin
            put_byte(ChQuote);
            live = 1'b0;
        end
        // Trailing bytes that a closed or failed string must swallow.
        if (!live) begin
            repeat ($urandom_range(2)) begin
                put_byte(8'($urandom()));
            end
        end
    endtask

    // Directed opening: range ends of plain bytes, a quoted and a doubled
    // backslash, a surrogate pair in mixed case, the closing quote and a
    // byte after it, then a control character, a bad escape and bad hex,
    // each opened by a restart.
    localparam logic [8:0] Directed [29] = '{
        {1'b1, 8'h20}, {1'b0, 8'hFF}, {1'b0, 8'h7F},
        {1'b0, 8'h5C}, {1'b0, 8'h22}, {1'b0, 8'h5C}, {1'b0, 8'h5C},
        {1'b0, 8'h5C}, {1'b0, 8'h75}, {1'b0, 8'h44}, {1'b0, 8'h38},
        {1'b0, 8'h33}, {1'b0, 8'h64},
        {1'b0, 8'h5C}, {1'b0, 8'h75}, {1'b0, 8'h64}, {1'b0, 8'h63},
        {1'b0, 8'h30}, {1'b0, 8'h30},
        {1'b0, 8'h22}, {1'b0, 8'h78},
        {1'b1, 8'h1F}, {1'b0, 8'h61},
        {1'b1, 8'h5C}, {1'b0, 8'h71},
        {1'b1, 8'h5C}, {1'b0, 8'h75}, {1'b0, 8'h30}, {1'b0, 8'h67}
    };

    initial begin
        int guard;
        int fails;
        rx_ch.valid   <= 1'b0;
        rx_ch.in_byte <= 8'h00;
        rx_ch.restart <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (Directed[i]) begin
            restart_next = Directed[i][8];
            put_byte(Directed[i][7:0]);
        end

        for (int p = 0; p < 4; p++) begin
            idle_pct  = IdlePct[p];
            stall_pct = StallPct[p];
            while (fed < (p + 1) * Items / 4) begin
                put_string();
            end
        end

        // Drain: let the checker register the last byte, then wait for every
        // expected beat and for any strays behind it.
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        guard = 0;
        while (pending != 0 && guard < 20000) begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);

        fails = mismatches;
        if (pending != 0) begin
            $display("%0d expected beats never arrived", pending);
            fails++;
        end
        $display("Fed %0d string bytes over four idling phases with restarts and noise.",
                 fed);
        $display("Checked %0d result beats, of them %0d end marks and %0d error marks.",
                 beats_checked, end_marks, error_marks);
        if (fails == 0) begin
            $display("RESULT: OK");
        end
        else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
sv/jsu_pkg.sv
sv/jsu_in_if.sv
sv/jsu_out_if.sv
sv/json_string_unescape_utf8_top.sv
tb/sv/jsu_decode_checker.sv
tb/sv/tb_json_string_unescape_utf8_top.sv
